>>> sv/wsts_pkg.sv
// Shared types and codes of the work-stealing task scheduler.
`default_nettype none
package wsts_pkg;

  localparam logic [1:0] OP_PUSH     = 2'd0;
  localparam logic [1:0] OP_FETCH    = 2'd1;
  localparam logic [1:0] OP_COMPLETE = 2'd2;

  localparam logic [1:0] SRC_OWN   = 2'd0;
  localparam logic [1:0] SRC_STEAL = 2'd1;
  localparam logic [1:0] SRC_NONE  = 2'd2;

  localparam logic [31:0] RNG_SEED    = 32'h9E3779B9;
  localparam logic [13:0] PENDING_MAX = 14'h3FFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  worker;
    logic [31:0] task_value;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] task_out;
    logic [1:0]  source;
    logic [2:0]  victim;
    logic        all_done;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MODR,
    ST_SCAN,
    ST_DONE
  } state_t;

  function automatic logic [31:0] rng_next(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage
`default_nettype wire

>>> sv/work_stealing_task_scheduler_core.sv
// Top level: per-worker ring deques in a shared task memory with stealing.
`default_nettype none
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------
//  in      | in        | in_valid/in_ready   | in_data  (opcode/worker/task)
//  out     | out       | out_valid/out_ready | out_data (one per request)
//  cfg     | in        | cfg_valid/cfg_ready | cfg_data (worker_count)
//
// Push, complete and own-deque fetch pass through accept, pointer lookup and
// result. A stealing fetch adds a fold of the scan start into range and a
// scan that probes up to 7 deques; the single read port of the pointer
// registers sets this, one deque examined per cycle.
// Reset clears pointers and pending count, seeds the generators and sets worker_count = 8; the
// task memory is not cleared. A stalled output holds the engine in its
// result state; one request is in flight at a time.
module work_stealing_task_scheduler_core #(
  parameter int NUM_WORKERS = 8,
  parameter int QUEUE_DEPTH = 1024,
  parameter int TASK_WIDTH  = 32
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wsts_pkg::req_t    in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output wsts_pkg::rsp_t    out_data,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire [3:0]         cfg_data
);
  import wsts_pkg::*;

  localparam int SPAN = 2 * QUEUE_DEPTH;
  localparam int PW   = $clog2(SPAN);
  localparam int WIW  = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int DEPTH = NUM_WORKERS * QUEUE_DEPTH;
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // per-worker control state, read at one chosen worker per cycle
  logic [PW-1:0]  bottom_ptr [NUM_WORKERS];
  logic [PW-1:0]  top_ptr    [NUM_WORKERS];
  logic [31:0]    rng_word   [NUM_WORKERS];
  logic [13:0]    pending;
  logic [3:0]     worker_count;

  // shared task memory
  logic [TASK_WIDTH-1:0] task_mem [DEPTH];
  logic [TASK_WIDTH-1:0] rdata;

  state_t state, state_next;

  // request being worked
  logic [1:0]  op;
  logic [2:0]  me;
  logic [31:0] val;
  logic [WIW-1:0] sel;        // worker whose pointers are looked at
  logic [4:0]  cur;           // scan position
  logic [3:0]  kcnt;          // victims probed
  logic [3:0]  n_eff;

  // staged result
  logic        r_ok, r_done, r_use_mem;
  logic [1:0]  r_src;
  logic [2:0]  r_vic;

  // lookup of the selected worker
  logic [PW-1:0] b_sel, t_sel, b_dec, b_inc, t_inc, slot_b, slot_bd, slot_t;
  logic [PW:0]   fill;
  logic          me_ok, empty;
  logic [AW-1:0] base_addr;
  logic          last_probe;

  function automatic logic [PW-1:0] p_inc(input logic [PW-1:0] p);
    return ({1'b0, p} + 1'b1 >= (PW+1)'(SPAN)) ? '0 : PW'({1'b0, p} + 1'b1);
  endfunction

  function automatic logic [PW-1:0] p_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(SPAN - 1) : p - 1'b1;
  endfunction

  function automatic logic [PW-1:0] p_slot(input logic [PW-1:0] p);
    return ({1'b0, p} >= (PW+1)'(QUEUE_DEPTH)) ? PW'({1'b0, p} - (PW+1)'(QUEUE_DEPTH)) : p;
  endfunction

  always_comb begin
    b_sel   = bottom_ptr[sel];
    t_sel   = top_ptr[sel];
    fill    = (b_sel >= t_sel) ? {1'b0, b_sel} - {1'b0, t_sel}
                               : {1'b0, b_sel} + (PW+1)'(SPAN) - {1'b0, t_sel};
    empty   = (fill == '0);
    b_dec   = p_dec(b_sel);
    b_inc   = p_inc(b_sel);
    t_inc   = p_inc(t_sel);
    slot_b  = p_slot(b_sel);
    slot_bd = p_slot(b_dec);
    slot_t  = p_slot(t_sel);
    base_addr = AW'(sel) * AW'(QUEUE_DEPTH);
    me_ok   = (32'(me) < NUM_WORKERS);
    last_probe = ({1'b0, kcnt} + 5'd1 >= {1'b0, n_eff} - 5'd1);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_LOOK;
      ST_LOOK: begin
        if (me_ok && op == OP_FETCH && empty && n_eff > 4'd1) state_next = ST_MODR;
        else state_next = ST_DONE;
      end
      ST_MODR: if (cur < {1'b0, n_eff}) state_next = ST_SCAN;
      ST_SCAN: begin
        if ((cur[2:0] != me || cur[4:3] != '0) && !empty) state_next = ST_DONE;
        else if (last_probe) state_next = ST_DONE;
      end
      ST_DONE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    cfg_ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // clamped worker count
  always_comb begin
    if (worker_count == 4'd0) n_eff = 4'd1;
    else if (32'(worker_count) > NUM_WORKERS) n_eff = 4'(NUM_WORKERS);
    else n_eff = worker_count;
  end

  // control state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_WORKERS; w++) begin
        bottom_ptr[w] <= '0;
        top_ptr[w]    <= '0;
        rng_word[w]   <= RNG_SEED ^ 32'(w);
      end
      pending      <= '0;
      worker_count <= 4'd8;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) worker_count <= cfg_data;
      // a new result may replace the one leaving in the same cycle
      if (state == ST_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: ;
        ST_LOOK: begin
          if (me_ok && op == OP_PUSH && fill < (PW+1)'(QUEUE_DEPTH)) begin
            bottom_ptr[sel] <= b_inc;
            if (pending != PENDING_MAX) pending <= pending + 14'd1;
          end else if (me_ok && op == OP_COMPLETE) begin
            if (pending != '0) pending <= pending - 14'd1;
          end else if (me_ok && op == OP_FETCH) begin
            if (!empty) begin
              if (b_dec == t_sel) top_ptr[sel] <= t_inc;
              else bottom_ptr[sel] <= b_dec;
            end else begin
              rng_word[sel] <= rng_next(rng_word[sel]);
            end
          end
        end
        ST_MODR: ;
        ST_SCAN: begin
          if ((cur[2:0] != me || cur[4:3] != '0) && !empty) top_ptr[sel] <= t_inc;
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        op  <= in_data.opcode;
        me  <= in_data.worker;
        val <= in_data.task_value;
        sel <= WIW'(in_data.worker);
        r_ok <= 1'b0; r_src <= SRC_NONE; r_vic <= '0;
        r_done <= 1'b0; r_use_mem <= 1'b0;
      end
      ST_LOOK: begin
        if (me_ok && op == OP_PUSH && fill < (PW+1)'(QUEUE_DEPTH)) begin
          r_ok <= 1'b1;
        end else if (me_ok && op == OP_FETCH) begin
          if (!empty) begin
            r_ok <= 1'b1; r_src <= SRC_OWN; r_use_mem <= 1'b1;
          end else begin
            cur  <= 5'(me) + 5'd1 + 5'(rng_word[sel][2:0]);
            kcnt <= '0;
            r_done <= (pending == '0);   // final unless a steal succeeds
          end
        end
      end
      ST_MODR: begin
        if (cur >= {1'b0, n_eff}) cur <= cur - {1'b0, n_eff};
        else sel <= WIW'(cur);
      end
      ST_SCAN: begin
        if ((cur[2:0] != me || cur[4:3] != '0) && !empty) begin
          r_ok <= 1'b1; r_src <= SRC_STEAL; r_vic <= cur[2:0];
          r_use_mem <= 1'b1; r_done <= 1'b0;
        end else begin
          kcnt <= kcnt + 4'd1;
          if (cur + 5'd1 == {1'b0, n_eff}) begin
            cur <= '0; sel <= '0;
          end else begin
            cur <= cur + 5'd1; sel <= WIW'(cur + 5'd1);
          end
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_data.ok       <= r_ok;
          out_data.task_out <= r_use_mem ? 32'(64'(rdata)) : 32'd0;
          out_data.source   <= r_src;
          out_data.victim   <= r_vic;
          out_data.all_done <= r_done;
        end
      end
      default: ;
    endcase
  end

  // task memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (state == ST_LOOK && me_ok && op == OP_PUSH && fill < (PW+1)'(QUEUE_DEPTH))
      task_mem[base_addr + AW'(slot_b)] <= TASK_WIDTH'(64'(val));
    if (state == ST_LOOK && !empty)
      rdata <= task_mem[base_addr + AW'(slot_bd)];
    else if (state == ST_SCAN && !empty)
      rdata <= task_mem[base_addr + AW'(slot_t)];
  end

endmodule
`default_nettype wire

>>> sv/wsts_checker.sv
// Port-level checks of the scheduler core and their binding.
`default_nettype none
module wsts_checker (
  input wire            clk,
  input wire            rst,
  input wire            in_valid,
  input wire            in_ready,
  input wsts_pkg::req_t in_data,
  input wire            out_valid,
  input wire            out_ready,
  input wsts_pkg::rsp_t out_data
);
  import wsts_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one in flight");

  a_none_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.source == SRC_NONE |->
      out_data.task_out == 32'd0 && out_data.victim == 3'd0)
    else $error("no-task result carries data");

  a_done_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.all_done |-> !out_data.ok && out_data.source == SRC_NONE)
    else $error("all_done with a task");

endmodule

bind work_stealing_task_scheduler_core wsts_checker u_wsts_checker (.*);
`default_nettype wire
